>>> rtl/cansd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansd_pkg
// Shared constants, register codes and types for the CAN signal field decoder.
// ----------------------------------------------------------------------------
package cansd_pkg;

  localparam int MAX_BYTES   = 8;
  localparam int PAYLOAD_W   = 64;
  localparam int LEN_CODE_W  = 4;
  localparam int START_W     = 6;
  localparam int BLEN_W      = 7;
  localparam int OFFSET_W    = 48;
  localparam int SCALE_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // offset-added value: raw shifted up by the fraction bits, a carry bit and a sign bit
  localparam int SUM_W       = PAYLOAD_W + FRAC_W + 2;
  localparam int PROD_W      = SUM_W + SCALE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BIT  = 3'd0,
    CFG_BIT_LENGTH = 3'd1,
    CFG_BYTE_ORDER = 3'd2,
    CFG_OFFSET     = 3'd3,
    CFG_SCALE      = 3'd4
  } cfg_index_t;

  localparam logic BYTE_ORDER_MOTOROLA = 1'b0;
  localparam logic BYTE_ORDER_INTEL    = 1'b1;

  typedef struct packed {
    logic [START_W-1:0]  start_bit;
    logic [BLEN_W-1:0]   bit_length;
    logic                byte_order;
    logic [OFFSET_W-1:0] offset;
    logic [SCALE_W-1:0]  scale;
  } cansd_cfg_t;

  // load enables of the arithmetic stages
  typedef struct packed {
    logic sum;
    logic mul;
    logic res;
  } cansd_stage_en_t;

endpackage

>>> rtl/can_signal_field_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_field_decoder_top
// CAN signal field decoder: extracts one DBC signal from a frame payload and
// scales it to a saturated unsigned fixed-point value.
// ----------------------------------------------------------------------------
// One word per cycle in and out while out_stall is low; each word passes
// the input register, extraction, offset add, partial products, and final
// sum and saturation stages in turn. Stages that hold no word keep filling
// while the output is stalled, so input stall rises only once all five stages
// are full.
// Registers on the cfg port: 0 start_bit, 1 bit_length, 2 byte_order
// (0 Motorola, 1 Intel), 3 offset (signed Q32.16), 4 scale (signed Q16.16);
// other indexes are ignored. Write them only while no word is in flight.
module can_signal_field_decoder_top
  import cansd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAYLOAD_W-1:0]  payload,
  input  logic [LEN_CODE_W-1:0] length_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PAYLOAD_W-1:0]  raw_value,
  output logic [PAYLOAD_W-1:0]  scaled_value,
  output logic                  field_valid,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cansd_cfg_t           cfg;
  logic [4:0]           vld;
  logic [4:0]           en;
  cansd_stage_en_t      sen;

  logic [PAYLOAD_W-1:0]  payload_q;
  logic [LEN_CODE_W-1:0] length_code_q;
  logic [PAYLOAD_W-1:0]  raw_x;
  logic                  fv_x;
  logic [PAYLOAD_W-1:0]  raw_e;
  logic                  fv_e;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_bit  <= '0;
      cfg.bit_length <= BLEN_W'(8);
      cfg.byte_order <= BYTE_ORDER_INTEL;
      cfg.offset     <= '0;
      cfg.scale      <= SCALE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_BIT:  cfg.start_bit  <= cfg_data[START_W-1:0];
        CFG_BIT_LENGTH: cfg.bit_length <= cfg_data[BLEN_W-1:0];
        CFG_BYTE_ORDER: cfg.byte_order <= cfg_data[0];
        CFG_OFFSET:     cfg.offset     <= cfg_data[OFFSET_W-1:0];
        CFG_SCALE:      cfg.scale      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its word moves on
  assign en[4] = !vld[4] || !out_stall;
  assign en[3] = !vld[3] || en[4];
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];

  assign in_stall  = !en[0];
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      payload_q     <= payload;
      length_code_q <= length_code;
    end
  end

  cansd_extract u_extract (
    .payload     (payload_q),
    .length_code (length_code_q),
    .cfg         (cfg),
    .raw         (raw_x),
    .valid       (fv_x)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      raw_e <= raw_x;
      fv_e  <= fv_x;
    end
  end

  assign sen.sum = en[2];
  assign sen.mul = en[3];
  assign sen.res = en[4];

  cansd_scale u_scale (
    .clk          (clk),
    .en           (sen),
    .cfg          (cfg),
    .raw          (raw_e),
    .fvalid       (fv_e),
    .raw_value    (raw_value),
    .scaled_value (scaled_value),
    .field_valid  (field_valid)
  );

endmodule

>>> rtl/cansd_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansd_extract
// Signal field extraction: range check and one barrel shift plus mask for
// both Intel and Motorola layouts.
// ----------------------------------------------------------------------------
module cansd_extract
  import cansd_pkg::*;
(
  input  logic [PAYLOAD_W-1:0]  payload,
  input  logic [LEN_CODE_W-1:0] length_code,
  input  cansd_cfg_t            cfg,
  output logic [PAYLOAD_W-1:0]  raw,
  output logic                  valid
);

  function automatic logic [PAYLOAD_W-1:0] low_mask(input logic [BLEN_W-1:0] n);
    logic [PAYLOAD_W-1:0] m;
    if (n >= BLEN_W'(PAYLOAD_W)) begin
      m = '1;
    end else begin
      m = (PAYLOAD_W'(1) << n[START_W-1:0]) - PAYLOAD_W'(1);
    end
    return m;
  endfunction

  logic [LEN_CODE_W-1:0] nb;
  logic [BLEN_W-1:0]     total;
  logic [PAYLOAD_W-1:0]  rev;
  logic                  intel_ok;
  logic                  moto_ok;
  logic [9:0]            low;
  logic [9:0]            moto_sh;
  logic [START_W-1:0]    amt;
  logic [PAYLOAD_W-1:0]  src;
  logic [PAYLOAD_W-1:0]  shifted;

  assign nb    = (length_code > LEN_CODE_W'(MAX_BYTES)) ? LEN_CODE_W'(MAX_BYTES) : length_code;
  assign total = {nb, 3'b000};

  // byte 0 moves to the top so the present bytes read as one big-endian word
  always_comb begin
    for (int k = 0; k < MAX_BYTES; k++) begin
      rev[8*(MAX_BYTES-1-k) +: 8] = payload[8*k +: 8];
    end
  end

  assign intel_ok = (cfg.bit_length != '0) &&
                    ((8'(cfg.start_bit) + 8'(cfg.bit_length)) <= 8'(total));

  // lowest field bit inside the big-endian word, negative when it runs off the end
  assign low = 10'(total) + 10'(cfg.start_bit[2:0]) - 10'd7
             - 10'({cfg.start_bit[5:3], 3'b000}) - 10'(cfg.bit_length);

  assign moto_ok = (cfg.bit_length != '0) && (cfg.bit_length <= BLEN_W'(PAYLOAD_W)) &&
                   (BLEN_W'(cfg.start_bit) < total) && !low[9];

  // shift on the full reversed word, independent of the byte count
  assign moto_sh = 10'd57 - 10'({cfg.start_bit[5:3], 3'b000})
                 + 10'(cfg.start_bit[2:0]) - 10'(cfg.bit_length);

  assign amt     = (cfg.byte_order == BYTE_ORDER_INTEL) ? cfg.start_bit : moto_sh[START_W-1:0];
  assign src     = (cfg.byte_order == BYTE_ORDER_INTEL) ? payload : rev;
  assign shifted = src >> amt;

  assign valid = (cfg.byte_order == BYTE_ORDER_INTEL) ? intel_ok : moto_ok;
  assign raw   = valid ? (shifted & low_mask(cfg.bit_length)) : '0;

endmodule

>>> rtl/cansd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cansd_scale
// Offset add, split multiply and saturation, three register stages, ending in
// the result register.
// ----------------------------------------------------------------------------
module cansd_scale
  import cansd_pkg::*;
(
  input  logic                 clk,
  input  cansd_stage_en_t      en,
  input  cansd_cfg_t           cfg,
  input  logic [PAYLOAD_W-1:0] raw,
  input  logic                 fvalid,
  output logic [PAYLOAD_W-1:0] raw_value,
  output logic [PAYLOAD_W-1:0] scaled_value,
  output logic                 field_valid
);

  localparam int PP2_W = PROD_W - 64;

  // offset stage
  logic [SUM_W-1:0]     sum_next;
  logic [SUM_W-1:0]     mag_next;
  logic [SUM_W-1:0]     mag;
  logic                 sum_neg;
  logic [PAYLOAD_W-1:0] raw_s;
  logic                 fv_s;

  // multiply stage
  logic [SCALE_W-1:0]   sm;
  logic [63:0]          pp0;
  logic [63:0]          pp1;
  logic [PP2_W-1:0]     pp2;
  logic                 neg;
  logic [PAYLOAD_W-1:0] raw_m;
  logic                 fv_m;

  // result stage
  logic [PROD_W-1:0]    prod;
  logic [PAYLOAD_W-1:0] scaled_next;

  assign sum_next = SUM_W'({raw, {FRAC_W{1'b0}}})
                  + {{(SUM_W-OFFSET_W){cfg.offset[OFFSET_W-1]}}, cfg.offset};
  assign mag_next = sum_next[SUM_W-1] ? (~sum_next + SUM_W'(1)) : sum_next;

  always_ff @(posedge clk) begin
    if (en.sum) begin
      mag     <= mag_next;
      sum_neg <= sum_next[SUM_W-1];
      raw_s   <= raw;
      fv_s    <= fvalid;
    end
  end

  assign sm = cfg.scale[SCALE_W-1] ? (~cfg.scale + SCALE_W'(1)) : cfg.scale;

  // three partial products of the magnitude limbs
  always_ff @(posedge clk) begin
    if (en.mul) begin
      pp0   <= 64'(mag[31:0]) * 64'(sm);
      pp1   <= 64'(mag[63:32]) * 64'(sm);
      pp2   <= PP2_W'(mag[SUM_W-1:64]) * PP2_W'(sm);
      neg   <= sum_neg ^ cfg.scale[SCALE_W-1];
      raw_m <= raw_s;
      fv_m  <= fv_s;
    end
  end

  assign prod = PROD_W'(pp0) + PROD_W'({pp1, 32'b0}) + {pp2, 64'b0};

  always_comb begin
    if (neg) begin
      scaled_next = '0;
    end else if (|prod[PROD_W-1:96]) begin
      scaled_next = '1;
    end else begin
      scaled_next = prod[95:32];
    end
  end

  always_ff @(posedge clk) begin
    if (en.res) begin
      raw_value    <= raw_m;
      scaled_value <= scaled_next;
      field_valid  <= fv_m;
    end
  end

endmodule
